>>> rtl/fixed_point_radix_to_ascii_defines.svh
// Assertion macros shared by the radix-to-ASCII converter modules.
`ifndef FIXED_POINT_RADIX_TO_ASCII_DEFINES_SVH
`define FIXED_POINT_RADIX_TO_ASCII_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define FRTA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define FRTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/frta_pkg.sv
// Shared constants, types and helper functions of the radix-to-ASCII converter.
`default_nettype none
package frta_pkg;

  // Field widths.
  localparam int INT_W   = 31;
  localparam int FRAC_W  = 32;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Parameter defaults.
  localparam int FRAC_DIGITS_DEF = 9;
  localparam int INT_DIGITS_DEF  = 32;

  // Divider: quotient bits resolved per cycle and the padded dividend width.
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (INT_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Radix limits and reset value.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // Character codes.
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0]  CHAR_F    = 7'h46;
  localparam logic [CHAR_W-1:0]  CHAR_DOT  = 7'h2E;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_INT_ZERO,
    ST_RD_WAIT,
    ST_INT_EMIT,
    ST_DOT,
    ST_FRAC_ZERO,
    ST_FRAC
  } state_t;

  // Source of the next character loaded into the output register.
  typedef enum logic [1:0] {
    CH_ZERO,
    CH_DIGIT,
    CH_DOT,
    CH_FRAC
  } char_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      start;
    logic      div_step;
    logic      held_dec;
    logic      load;
    char_sel_t sel;
    logic      last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_first;
    logic div_zero;
    logic held_full;
    logic held_zero;
    logic held_one;
    logic frac_zero;
    logic frac_last;
    logic slot_free;
  } sts_t;

  // Digit value to its ASCII character, 0-9 then A-F.
  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d - DIGIT_TEN};
    end
    if (c > CHAR_F) begin
      c = CHAR_F;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/frta_in_if.sv
// Input channel: one number per word, integer part and Q0.32 fraction.
`default_nettype none
interface frta_in_if
  import frta_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [INT_W-1:0]  int_part;
  logic [FRAC_W-1:0] frac_part;

  modport source (output valid, output int_part, output frac_part, input ready);
  modport sink   (input valid, input int_part, input frac_part, output ready);
endinterface
`default_nettype wire

>>> rtl/frta_out_if.sv
// Output channel: one ASCII character per word with an end-of-string flag.
`default_nettype none
interface frta_out_if
  import frta_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/frta_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module frta_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/frta_ctrl.sv
// Controller state machine that sequences division, digit output and fraction.
`default_nettype none
`include "fixed_point_radix_to_ascii_defines.svh"
module frta_ctrl
  import frta_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = CH_ZERO;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Between digits, stop once the quotient is zero or the store is full.
        if (sts.div_first && (sts.div_zero || sts.held_full)) begin
          state_nxt = sts.held_zero ? ST_INT_ZERO : ST_INT_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_INT_ZERO: begin
        if (sts.slot_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = CH_ZERO;
          state_nxt = ST_DOT;
        end
      end
      ST_RD_WAIT: begin
        // The store read of the next digit is registered here, for use in ST_INT_EMIT.
        state_nxt = ST_INT_EMIT;
      end
      ST_INT_EMIT: begin
        if (sts.slot_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = CH_DIGIT;
          cmd.held_dec = 1'b1;
          state_nxt    = sts.held_one ? ST_DOT : ST_RD_WAIT;
        end
      end
      ST_DOT: begin
        if (sts.slot_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = CH_DOT;
          state_nxt = sts.frac_zero ? ST_FRAC_ZERO : ST_FRAC;
        end
      end
      ST_FRAC_ZERO: begin
        if (sts.slot_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = CH_ZERO;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FRAC: begin
        if (sts.slot_free) begin
          cmd.load = 1'b1;
          cmd.sel  = CH_FRAC;
          cmd.last = sts.frac_last;
          if (sts.frac_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A character is only loaded into a free output register.
  `FRTA_ASSERT_IMPL(a_load_needs_slot, cmd.load, sts.slot_free, "load into busy output")
  // The final character of a string returns the controller to idle.
  `FRTA_ASSERT_NEXT(a_last_ends_item, cmd.load && cmd.last, state_r == ST_IDLE,
                    "last character did not end the item")
  // Digits are only sent while the store still holds some.
  `FRTA_ASSERT_IMPL(a_emit_has_digit, state_r == ST_INT_EMIT, !sts.held_zero,
                    "digit output with empty store")

endmodule
`default_nettype wire

>>> rtl/frta_dpath.sv
// Datapath: radix register, iterative divider, digit store, fraction multiply, output.
`default_nettype none
`include "fixed_point_radix_to_ascii_defines.svh"
module frta_dpath
  import frta_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int INT_DIGITS  = INT_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [RADIX_W-1:0] cfg_wdata,
  input  wire logic [INT_W-1:0]   in_int_part,
  input  wire logic [FRAC_W-1:0]  in_frac_part,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  frta_out_if.source              out_ch
);

  localparam int HW = $clog2(INT_DIGITS + 1);
  localparam int AW = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
  localparam int KW = $clog2(FRAC_DIGITS + 1);
  localparam int PW = FRAC_W + RADIX_W;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] base_r, base_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [HW-1:0]      held_r, held_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [KW-1:0]      kcnt_r, kcnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [RADIX_W-1:0] base_clamp;
  logic [DIV_W-1:0]   div_sh;
  logic [RADIX_W-1:0] div_rr;
  logic [DIGIT_W-1:0] div_rem;
  logic               div_last;
  logic [PW-1:0]      prod;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  // Radix register; out-of-range values are clamped when an item starts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  always_comb begin
    case (radix_r) inside
      [5'd0:5'd1]:  base_clamp = RADIX_MIN;
      [5'd2:5'd16]: base_clamp = radix_r;
      default:      base_clamp = RADIX_MAX;
    endcase
  end

  // Restoring division, DIV_STEP quotient bits per cycle, remainder below the base.
  always_comb begin
    div_sh  = div_r;
    div_rem = (dcnt_r == '0) ? '0 : rem_r;
    div_rr  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      div_rr = {div_rem, div_sh[DIV_W-1]};
      div_sh = {div_sh[DIV_W-2:0], 1'b0};
      if (div_rr >= base_r) begin
        div_rr    = div_rr - base_r;
        div_sh[0] = 1'b1;
      end
      div_rem = div_rr[DIGIT_W-1:0];
    end
  end

  assign div_last = (dcnt_r == DCNT_W'(DIV_CYCLES - 1));

  // One fraction digit: the integer part of fraction times base.
  assign prod = PW'(frac_r) * PW'(base_r);

  // Digit store, written at the fill count and read one below it.
  assign ram_we    = cmd.div_step && div_last;
  assign ram_waddr = held_r[AW-1:0];
  assign ram_raddr = AW'(held_r - HW'(1));

  frta_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(INT_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(div_rem),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Working registers, next values.
  always_comb begin
    base_nxt = base_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    dcnt_nxt = dcnt_r;
    held_nxt = held_r;
    frac_nxt = frac_r;
    kcnt_nxt = kcnt_r;
    if (cmd.start) begin
      base_nxt = base_clamp;
      div_nxt  = DIV_W'(in_int_part);
      dcnt_nxt = '0;
      held_nxt = '0;
      frac_nxt = in_frac_part;
      kcnt_nxt = '0;
    end
    if (cmd.div_step) begin
      div_nxt = div_sh;
      rem_nxt = div_rem;
      if (div_last) begin
        dcnt_nxt = '0;
        held_nxt = held_r + HW'(1);
      end else begin
        dcnt_nxt = dcnt_r + DCNT_W'(1);
      end
    end
    if (cmd.held_dec) begin
      held_nxt = held_r - HW'(1);
    end
    if (cmd.load && (cmd.sel == CH_FRAC)) begin
      frac_nxt = prod[FRAC_W-1:0];
      kcnt_nxt = kcnt_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    frac_r <= frac_nxt;
    kcnt_r <= kcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      held_r <= '0;
    end else begin
      dcnt_r <= dcnt_nxt;
      held_r <= held_nxt;
    end
  end

  // Output register: takes a new word when empty or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = cmd.last;
      case (cmd.sel)
        CH_ZERO:  out_char_nxt = CHAR_ZERO;
        CH_DIGIT: out_char_nxt = ascii_of(ram_rdata);
        CH_DOT:   out_char_nxt = CHAR_DOT;
        CH_FRAC:  out_char_nxt = ascii_of(prod[FRAC_W +: DIGIT_W]);
        default:  out_char_nxt = CHAR_ZERO;
      endcase
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  // Status for the controller.
  always_comb begin
    sts           = '0;
    sts.div_first = (dcnt_r == '0);
    sts.div_zero  = (div_r == '0);
    sts.held_full = (held_r == HW'(INT_DIGITS));
    sts.held_zero = (held_r == '0);
    sts.held_one  = (held_r == HW'(1));
    sts.frac_zero = (frac_r == '0);
    sts.frac_last = (prod[FRAC_W-1:0] == '0) || (kcnt_r == KW'(FRAC_DIGITS - 1));
    sts.slot_free = !out_valid_r || out_ch.ready;
  end

  // The store is only written below its depth.
  `FRTA_ASSERT_IMPL(a_store_in_range, ram_we, held_r < HW'(INT_DIGITS),
                    "digit store written past its depth")

endmodule
`default_nettype wire

>>> rtl/fixed_point_radix_to_ascii.sv
// Top level of the fixed-point radix-to-ASCII converter.
//
//  channel | direction | word                         | handshake
//  --------+-----------+------------------------------+-------------------
//  in_ch   | in        | int_part[30:0], frac_part    | valid and ready
//  out_ch  | out       | char_code[6:0], last         | valid and ready
//  cfg     | in        | cfg_wdata[4:0] radix         | cfg_we, no wait
//
// The divider resolves each integer digit, and a check state ends the division; each digit
// after the first then waits in ST_RD_WAIT for the registered store read before it is
// sent, while the point and each fraction digit are sent without such a wait.
// Reset (rst_n low, synchronous) sets the radix to 10; the store needs no clearing.
// A stalled output holds the controller; one new item is taken only when idle.
`default_nettype none
module fixed_point_radix_to_ascii
  import frta_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int INT_DIGITS  = INT_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [RADIX_W-1:0] cfg_wdata,
  frta_in_if.sink                 in_ch,
  frta_out_if.source              out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  frta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Arithmetic, digit store and output register.
  frta_dpath #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .INT_DIGITS (INT_DIGITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_int_part (in_ch.int_part),
    .in_frac_part(in_ch.frac_part),
    .cmd         (cmd),
    .sts         (sts),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
